### src/srf_pkg.sv
package srf_pkg;

    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_READ   = 3'd1;
    localparam logic [2:0] OP_ROTATE = 3'd2;
    localparam logic [2:0] OP_FLIP_V = 3'd3;
    localparam logic [2:0] OP_FLIP_H = 3'd4;

    localparam logic [2:0] OR_FC = 3'b001;
    localparam logic [2:0] OR_FR = 3'b010;
    localparam logic [2:0] OR_SW = 3'b100;

    localparam logic [7:0] BLANK = 8'd32;

    localparam int CRD_W = 8;
    localparam int Q_DEPTH = 2;
    localparam int Q_PW = 1;

    localparam logic [1:0] K_WRITE = 2'd0;
    localparam logic [1:0] K_READ  = 2'd1;
    localparam logic [1:0] K_BLANK = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [CRD_W-1:0] prow;
        logic [CRD_W-1:0] pcol;
        logic [7:0]       symbol;
    } t_cmd;

    typedef struct packed {
        logic push;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic clearing;
        logic pop;
    } t_bk_stat;

endpackage

### src/srf_front.sv
module srf_front #(
    parameter int SIDE = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  logic [2:0]   i_op,
    input  logic [5:0]   i_row,
    input  logic [5:0]   i_col,
    input  logic [7:0]   i_symbol,
    output logic         o_push,
    output srf_pkg::t_cmd o_cmd
);
    import srf_pkg::*;

    localparam logic [8:0] MAXC = 9'(SIDE - 1);
    localparam logic [8:0] SIDE_V = 9'(SIDE);

    logic [2:0] r_orient;
    logic [2:0] n_orient;
    logic [8:0] row_x;
    logic [8:0] col_x;
    logic [8:0] a;
    logic [8:0] b;
    logic [8:0] pr;
    logic [8:0] pc;
    logic       in_img;

    assign row_x  = {3'b000, i_row};
    assign col_x  = {3'b000, i_col};
    assign in_img = (row_x < SIDE_V) && (col_x < SIDE_V);

    always_comb begin
        a  = (r_orient & OR_SW) != 3'b000 ? col_x : row_x;
        b  = (r_orient & OR_SW) != 3'b000 ? row_x : col_x;
        pr = (r_orient & OR_FR) != 3'b000 ? MAXC - a : a;
        pc = (r_orient & OR_FC) != 3'b000 ? MAXC - b : b;
    end

    always_comb begin
        n_orient     = r_orient;
        o_push       = 1'b0;
        o_cmd.kind   = K_WRITE;
        o_cmd.prow   = pr[CRD_W-1:0];
        o_cmd.pcol   = pc[CRD_W-1:0];
        o_cmd.symbol = i_symbol;
        case (i_op)
            OP_WRITE: begin
                o_push = i_accept && in_img;
            end
            OP_READ: begin
                o_push     = i_accept;
                o_cmd.kind = in_img ? K_READ : K_BLANK;
            end
            OP_ROTATE: begin
                if ((r_orient & OR_SW) != 3'b000) begin
                    n_orient = (r_orient & ~OR_SW) ^ OR_FC;
                end else begin
                    n_orient = (r_orient | OR_SW) ^ OR_FR;
                end
            end
            OP_FLIP_V: begin
                n_orient = r_orient ^ (((r_orient & OR_SW) != 3'b000) ? OR_FC : OR_FR);
            end
            OP_FLIP_H: begin
                n_orient = r_orient ^ (((r_orient & OR_SW) != 3'b000) ? OR_FR : OR_FC);
            end
            default: begin
                n_orient = r_orient;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient <= 3'b000;
        end else if (i_accept) begin
            r_orient <= n_orient;
        end
    end

endmodule

### src/srf_queue.sv
module srf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  srf_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output srf_pkg::t_cmd o_cmd
);
    import srf_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_PW-1:0] r_wr_ptr;
    logic [Q_PW-1:0] r_rd_ptr;
    logic [Q_PW:0]   r_count;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == (Q_PW + 1)'(Q_DEPTH);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### src/srf_back.sv
module srf_back #(
    parameter int SIDE = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  srf_pkg::t_cmd    i_cmd,
    output srf_pkg::t_bk_stat o_stat,
    output logic             o_valid,
    output logic [7:0]       o_pixel
);
    import srf_pkg::*;

    localparam int DEPTH = SIDE * SIDE;
    localparam int CW = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam int AW = $clog2(DEPTH);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rdata;
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic          r_rd_vld;
    logic          r_rd_blank;
    logic          pop;
    logic          we;
    logic [AW-1:0] addr;
    logic [AW-1:0] cmd_addr;
    logic [7:0]    wdata;

    assign pop      = i_valid && !r_clearing;
    assign cmd_addr = AW'(i_cmd.prow[CW-1:0]) * AW'(SIDE) + AW'(i_cmd.pcol[CW-1:0]);
    assign we       = r_clearing || (pop && i_cmd.kind == K_WRITE);
    assign addr     = r_clearing ? r_clr_addr : cmd_addr;
    assign wdata    = r_clearing ? BLANK : i_cmd.symbol;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[addr] <= wdata;
        end else begin
            r_rdata <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_blank <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_rd_vld   <= pop && (i_cmd.kind == K_READ || i_cmd.kind == K_BLANK);
            r_rd_blank <= i_cmd.kind == K_BLANK;
        end
    end

    assign o_valid         = r_rd_vld;
    assign o_pixel         = r_rd_blank ? BLANK : r_rdata;
    assign o_stat.clearing = r_clearing;
    assign o_stat.pop      = pop;

endmodule

### src/square_image_rotate_flip.sv
// Square character image store, SIDE x SIDE pixels of 8 bits, with pixel
// write, pixel read, rotate clockwise, vertical flip and horizontal flip.
// After reset the store is swept to spaces one pixel per cycle, with busy
// high throughout. After that one command is taken per cycle while busy
// is low: whole-image transforms only change the orientation in the front
// end, and each pixel access is one operation on the single store port. A
// read result appears with o_valid for one cycle, after the command has
// passed through the command queue and the registered store read; the
// receiver cannot stall, so every transfer on o_pixel must be taken in the
// cycle it is shown. Writes and reads outside the image are dropped and
// give a space, respectively.
module square_image_rotate_flip #(
    parameter int SIDE = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_op,
    input  logic [5:0] i_row,
    input  logic [5:0] i_col,
    input  logic [7:0] i_symbol,
    output logic       o_valid,
    output logic [7:0] o_pixel
);
    import srf_pkg::*;

    t_cmd     fr_cmd;
    t_cmd     q_cmd;
    t_q_stat  q_stat;
    t_bk_stat bk_stat;
    logic     accept;
    logic     q_valid;
    logic     q_push;
    logic     q_full;

    assign q_stat = '{push: q_push, full: q_full};
    assign busy   = bk_stat.clearing || q_stat.full;
    assign accept = start && !busy;

    srf_front #(
        .SIDE(SIDE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_op    (i_op),
        .i_row   (i_row),
        .i_col   (i_col),
        .i_symbol(i_symbol),
        .o_push  (q_push),
        .o_cmd   (fr_cmd)
    );

    srf_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (fr_cmd),
        .i_pop  (bk_stat.pop),
        .o_valid(q_valid),
        .o_full (q_full),
        .o_cmd  (q_cmd)
    );

    srf_back #(
        .SIDE(SIDE)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .i_cmd  (q_cmd),
        .o_stat (bk_stat),
        .o_valid(o_valid),
        .o_pixel(o_pixel)
    );

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_stat.clearing |-> busy)
        else $error("command accepted during store clear");

    a_pop_no_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_stat.pop |-> !bk_stat.clearing)
        else $error("queue popped during store clear");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.push |-> !q_stat.full)
        else $error("push into full command queue");

    a_no_result_at_clear_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(bk_stat.clearing) |-> !o_valid)
        else $error("result before store clear finished");

endmodule
